// ----- rtl/core/swt_pkg.sv -----
// shared constants, codes and helpers for the shell word tokenizer
`timescale 1ns / 1ps

package swt_pkg;

    // default width of the line counter
    localparam int LINE_BITS_DEF = 16;
    // width of the reported line number
    localparam int LINE_OUT_W = 16;

    // characters of interest
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // scan mode codes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_AFTERNL = 3'd1;
    localparam logic [2:0] M_WORD    = 3'd2;
    localparam logic [2:0] M_WESC    = 3'd3;
    localparam logic [2:0] M_SQ      = 3'd4;
    localparam logic [2:0] M_DQ      = 3'd5;
    localparam logic [2:0] M_DESC    = 3'd6;

    // result kinds
    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_WORD = 3'd1;
    localparam logic [2:0] K_SEP  = 3'd2;
    localparam logic [2:0] K_LB   = 3'd3;
    localparam logic [2:0] K_ERR  = 3'd4;

    // input opcodes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // mode after an unquoted word byte
    function automatic logic [2:0] word_next(input logic [7:0] c);
        logic [2:0] m;
        begin
            m = M_WORD;
            if (c == CH_SQ)
            begin
                m = M_SQ;
            end
            else if (c == CH_DQ)
            begin
                m = M_DQ;
            end
            else if (c == CH_BSL)
            begin
                m = M_WESC;
            end
            return m;
        end
    endfunction

endpackage

// ----- rtl/core/shell_word_tokenizer_top.sv -----
// shell word tokenizer: byte-serial lexer with quoting, one tag per byte
// the result is registered: it is valid in the cycle after its input transfer
// throughput: one byte per cycle while out_ready holds; the scan mode and line counter
//   update in the same cycle as the input transfer, so bytes follow back to back
// reset: asynchronous active-low rst_n; mode goes idle, line count goes to
//   one, the result register empties
`timescale 1ns / 1ps

module shell_word_tokenizer_top #(
    parameter int LINE_BITS = swt_pkg::LINE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  in_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [2:0]  kind,
    output logic        word_first,
    output logic        word_closed,
    output logic [swt_pkg::LINE_OUT_W-1:0] line_number,
    output logic        input_done
);

    // lexer state
    logic [2:0]           mode_reg;
    logic [2:0]           mode_next;
    logic [LINE_BITS-1:0] line_reg;
    logic [LINE_BITS-1:0] line_next;

    // result register
    logic                            out_valid_reg;
    logic [7:0]                      out_byte_reg;
    logic [2:0]                      kind_reg;
    logic                            first_reg;
    logic                            closed_reg;
    logic [swt_pkg::LINE_OUT_W-1:0]  line_num_reg;
    logic                            done_reg;

    // result of the byte being transferred in
    logic [7:0]                      byte_res;
    logic [2:0]                      kind_res;
    logic                            first_res;
    logic                            closed_res;
    logic                            done_res;
    logic [swt_pkg::LINE_OUT_W-1:0]  line_num_res;
    logic                            idle_path;
    logic                            in_xfer;

    // a new byte enters whenever the result slot is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // mode machine: one step per byte
    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        byte_res   = in_byte;
        kind_res   = swt_pkg::K_NONE;
        first_res  = 1'b0;
        closed_res = 1'b0;
        done_res   = 1'b0;
        idle_path  = 1'b0;

        if (opcode == swt_pkg::OP_END)
        begin
            // end of input: error in quotes, close an open word
            done_res = 1'b1;
            byte_res = 8'h00;
            case (mode_reg)
                swt_pkg::M_SQ, swt_pkg::M_DQ, swt_pkg::M_DESC:
                begin
                    kind_res = swt_pkg::K_ERR;
                end
                swt_pkg::M_WORD, swt_pkg::M_WESC:
                begin
                    closed_res = 1'b1;
                end
                default:
                begin
                    kind_res = swt_pkg::K_NONE;
                end
            endcase
            mode_next = swt_pkg::M_IDLE;
        end
        else
        begin
            case (mode_reg)
                swt_pkg::M_WORD:
                begin
                    if (in_byte == swt_pkg::CH_SPACE || in_byte == swt_pkg::CH_SEMI ||
                        in_byte == swt_pkg::CH_NL)
                    begin
                        // word ends here, the delimiter is then taken as if idle
                        closed_res = 1'b1;
                        idle_path  = 1'b1;
                    end
                    else
                    begin
                        kind_res  = swt_pkg::K_WORD;
                        mode_next = swt_pkg::word_next(in_byte);
                    end
                end
                swt_pkg::M_WESC:
                begin
                    kind_res  = swt_pkg::K_WORD;
                    mode_next = swt_pkg::M_WORD;
                end
                swt_pkg::M_SQ:
                begin
                    kind_res = swt_pkg::K_WORD;
                    if (in_byte == swt_pkg::CH_SQ)
                    begin
                        mode_next = swt_pkg::M_WORD;
                    end
                end
                swt_pkg::M_DQ:
                begin
                    kind_res = swt_pkg::K_WORD;
                    if (in_byte == swt_pkg::CH_DQ)
                    begin
                        mode_next = swt_pkg::M_WORD;
                    end
                    else if (in_byte == swt_pkg::CH_BSL)
                    begin
                        mode_next = swt_pkg::M_DESC;
                    end
                end
                swt_pkg::M_DESC:
                begin
                    kind_res  = swt_pkg::K_WORD;
                    mode_next = swt_pkg::M_DQ;
                end
                default:
                begin
                    // idle, after a linebreak, or an unused code
                    idle_path = 1'b1;
                end
            endcase

            if (idle_path)
            begin
                if (in_byte == swt_pkg::CH_SPACE)
                begin
                    // skipped; an absorbing mode stays absorbing
                    kind_res = swt_pkg::K_NONE;
                    if (mode_reg != swt_pkg::M_AFTERNL)
                    begin
                        mode_next = swt_pkg::M_IDLE;
                    end
                end
                else if (in_byte == swt_pkg::CH_NL)
                begin
                    // every unquoted newline counts, saturating
                    if (line_reg != {LINE_BITS{1'b1}})
                    begin
                        line_next = line_reg + 1'b1;
                    end
                    if (mode_reg == swt_pkg::M_AFTERNL)
                    begin
                        kind_res = swt_pkg::K_NONE;
                    end
                    else
                    begin
                        kind_res = swt_pkg::K_LB;
                    end
                    mode_next = swt_pkg::M_AFTERNL;
                end
                else if (in_byte == swt_pkg::CH_SEMI)
                begin
                    kind_res  = swt_pkg::K_SEP;
                    mode_next = swt_pkg::M_IDLE;
                end
                else
                begin
                    kind_res  = swt_pkg::K_WORD;
                    first_res = 1'b1;
                    mode_next = swt_pkg::word_next(in_byte);
                end
            end
        end
    end

    // reported line number, clipped to the output width
    generate
        if (LINE_BITS > swt_pkg::LINE_OUT_W)
        begin : g_line_clip
            assign line_num_res = (|line_next[LINE_BITS-1:swt_pkg::LINE_OUT_W]) ?
                                  {swt_pkg::LINE_OUT_W{1'b1}} :
                                  line_next[swt_pkg::LINE_OUT_W-1:0];
        end
        else
        begin : g_line_ext
            assign line_num_res = swt_pkg::LINE_OUT_W'(line_next);
        end
    endgenerate

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= swt_pkg::M_IDLE;
            line_reg      <= LINE_BITS'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                mode_reg      <= mode_next;
                line_reg      <= line_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_byte_reg <= byte_res;
            kind_reg     <= kind_res;
            first_reg    <= first_res;
            closed_reg   <= closed_res;
            line_num_reg <= line_num_res;
            done_reg     <= done_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign kind        = kind_reg;
    assign word_first  = first_reg;
    assign word_closed = closed_reg;
    assign line_number = line_num_reg;
    assign input_done  = done_reg;

endmodule

// ----- rtl/core/swt_checker.sv -----
// port-level checks for the shell word tokenizer, bound to the top level
`timescale 1ns / 1ps

module swt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic [2:0]  kind,
    input logic        word_first,
    input logic        word_closed,
    input logic [swt_pkg::LINE_OUT_W-1:0] line_number,
    input logic        input_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
            && $stable(line_number) && $stable(input_done))
        else $error("result changed while stalled");

    // end marker never starts a word, echoes zero, gives no token
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && input_done |-> out_byte == 8'h00 && !word_first
            && (kind == swt_pkg::K_NONE || kind == swt_pkg::K_ERR))
        else $error("bad end of input result");

    // word start only on a word byte
    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_first |-> kind == swt_pkg::K_WORD)
        else $error("word start without word byte");

    // unmatched quote only at end of input, with no word close
    a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == swt_pkg::K_ERR |-> input_done && !word_closed)
        else $error("quote error outside end of input");

    // line count starts at one and never wraps to zero
    a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line_number != '0)
        else $error("line number zero");

endmodule

bind shell_word_tokenizer_top swt_checker u_swt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .kind        (kind),
    .word_first  (word_first),
    .word_closed (word_closed),
    .line_number (line_number),
    .input_done  (input_done)
);

// ----- tb/sv/shell_word_tokenizer_top_test.sv -----
// self-checking testbench for the shell word tokenizer: directed and random byte streams
`timescale 1ns / 1ps

module shell_word_tokenizer_top_test;

    // one input transfer as the sender sees it
    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } byte_item_t;

    // one result transfer, field for field as on the ports
    typedef struct packed {
        logic [7:0]                     echo;
        logic [2:0]                     kind;
        logic                           first;
        logic                           closed;
        logic [swt_pkg::LINE_OUT_W-1:0] line_no;
        logic                           done;
    } byte_tag_t;

    localparam int LB = swt_pkg::LINE_BITS_DEF;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // input channel, known from time zero
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       opcode = swt_pkg::OP_DATA;
    logic [7:0] in_byte = 8'h00;

    // result channel
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [7:0]                     out_byte;
    logic [2:0]                     kind;
    logic                           word_first;
    logic                           word_closed;
    logic [swt_pkg::LINE_OUT_W-1:0] line_number;
    logic                           input_done;

    // bytes waiting to be sent and tags waiting to come back
    byte_item_t byte_feed[$];
    byte_tag_t  tag_expect[$];

    // idle and stall rates in percent, set per phase
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    int unsigned mismatch_count = 0;

    // lexer state as the checker tracks it
    logic [2:0]    tok_mode = swt_pkg::M_IDLE;
    logic [LB-1:0] line_tally = 1;

    shell_word_tokenizer_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .kind        (kind),
        .word_first  (word_first),
        .word_closed (word_closed),
        .line_number (line_number),
        .input_done  (input_done)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // expected behavior
    // ------------------------------------------------------------------

    // mode entered after an unquoted word byte: quotes and backslash open
    // their regions at any position in a word
    function automatic logic [2:0] quote_entry_mode(input logic [7:0] c);
        logic [2:0] m;
        m = swt_pkg::M_WORD;
        if (c == swt_pkg::CH_SQ)
            m = swt_pkg::M_SQ;
        else if (c == swt_pkg::CH_DQ)
            m = swt_pkg::M_DQ;
        else if (c == swt_pkg::CH_BSL)
            m = swt_pkg::M_WESC;
        return m;
    endfunction

    // tag one accepted byte and advance the tracked lexer state
    function automatic byte_tag_t lex_byte(input byte_item_t it);
        logic [2:0] m;
        logic [7:0] c;
        logic       handled;
        byte_tag_t  r;
        r = '0;
        c = it.ch;
        m = tok_mode;
        handled = 1'b0;
        // unused mode codes behave as idle
        if (m > swt_pkg::M_DESC)
            m = swt_pkg::M_IDLE;
        r.echo = c;
        r.kind = swt_pkg::K_NONE;

        if (it.op == swt_pkg::OP_END)
        begin
            r.done = 1'b1;
            r.echo = 8'h00;
            // open quote or pending escape in quotes is an error,
            // an open word simply ends
            if (m == swt_pkg::M_SQ || m == swt_pkg::M_DQ || m == swt_pkg::M_DESC)
                r.kind = swt_pkg::K_ERR;
            else if (m == swt_pkg::M_WORD || m == swt_pkg::M_WESC)
                r.closed = 1'b1;
            m = swt_pkg::M_IDLE;
            handled = 1'b1;
        end
        else
        begin
            case (m)
                swt_pkg::M_WORD:
                begin
                    if (c == swt_pkg::CH_SPACE || c == swt_pkg::CH_SEMI
                        || c == swt_pkg::CH_NL)
                    begin
                        // word ends here, the byte is then taken as in idle
                        r.closed = 1'b1;
                        m = swt_pkg::M_IDLE;
                    end
                    else
                    begin
                        r.kind = swt_pkg::K_WORD;
                        m = quote_entry_mode(c);
                        handled = 1'b1;
                    end
                end
                swt_pkg::M_WESC:
                begin
                    r.kind = swt_pkg::K_WORD;
                    m = swt_pkg::M_WORD;
                    handled = 1'b1;
                end
                swt_pkg::M_SQ:
                begin
                    r.kind = swt_pkg::K_WORD;
                    if (c == swt_pkg::CH_SQ)
                        m = swt_pkg::M_WORD;
                    handled = 1'b1;
                end
                swt_pkg::M_DQ:
                begin
                    r.kind = swt_pkg::K_WORD;
                    if (c == swt_pkg::CH_DQ)
                        m = swt_pkg::M_WORD;
                    else if (c == swt_pkg::CH_BSL)
                        m = swt_pkg::M_DESC;
                    handled = 1'b1;
                end
                swt_pkg::M_DESC:
                begin
                    r.kind = swt_pkg::K_WORD;
                    m = swt_pkg::M_DQ;
                    handled = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // between tokens or absorbing after a linebreak
        if (!handled)
        begin
            if (c == swt_pkg::CH_SPACE)
            begin
                r.kind = swt_pkg::K_NONE;
            end
            else if (c == swt_pkg::CH_NL)
            begin
                // every unquoted newline counts, absorbed ones too
                if (line_tally != '1)
                    line_tally = line_tally + 1'b1;
                if (m == swt_pkg::M_AFTERNL)
                    r.kind = swt_pkg::K_NONE;
                else
                begin
                    r.kind = swt_pkg::K_LB;
                    m = swt_pkg::M_AFTERNL;
                end
            end
            else if (c == swt_pkg::CH_SEMI)
            begin
                r.kind = swt_pkg::K_SEP;
                m = swt_pkg::M_IDLE;
            end
            else
            begin
                r.kind = swt_pkg::K_WORD;
                r.first = 1'b1;
                m = quote_entry_mode(c);
            end
        end

        tok_mode = m;
        if (line_tally > {swt_pkg::LINE_OUT_W{1'b1}})
            r.line_no = '1;
        else
            r.line_no = line_tally[swt_pkg::LINE_OUT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input byte_tag_t want,
                                 input byte_tag_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $write("mismatch %0d (%s) at %0t: exp byte=%02h kind=%0d first=%b ",
                   mismatch_count, what, $time, want.echo, want.kind, want.first);
            $write("closed=%b line=%0d done=%b | ", want.closed, want.line_no, want.done);
            $display("got byte=%02h kind=%0d first=%b closed=%b line=%0d done=%b",
                     got.echo, got.kind, got.first, got.closed, got.line_no, got.done);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: feeds queued bytes, predicts each one as it transfers
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : byte_driver
        byte_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // the byte on the port transfers at this edge
            if (in_valid && in_ready)
                tag_expect.push_back(lex_byte('{op: opcode, ch: in_byte}));
            // load the next byte only when the port is free; a held byte
            // stays unchanged until it transfers
            if (!in_valid || in_ready)
            begin
                if (byte_feed.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    nxt = byte_feed.pop_front();
                    in_valid <= 1'b1;
                    opcode <= nxt.op;
                    in_byte <= nxt.ch;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result transfer against the oldest tag
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : tag_monitor
        byte_tag_t got;
        byte_tag_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{echo: out_byte, kind: kind, first: word_first,
                        closed: word_closed, line_no: line_number, done: input_done};
                if (tag_expect.size() == 0)
                begin
                    flag_mismatch("no tag pending", '0, got);
                end
                else
                begin
                    want = tag_expect.pop_front();
                    if (got.echo !== want.echo || got.kind !== want.kind
                        || got.first !== want.first || got.closed !== want.closed
                        || got.line_no !== want.line_no || got.done !== want.done)
                        flag_mismatch("wrong field", want, got);
                end
            end
            // random backpressure
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus building blocks
    // ------------------------------------------------------------------
    task automatic add_data(input logic [7:0] c);
        byte_feed.push_back('{op: swt_pkg::OP_DATA, ch: c});
    endtask

    // payload byte is random: the block must ignore it on the end marker
    task automatic add_end();
        byte_feed.push_back('{op: swt_pkg::OP_END, ch: 8'($urandom_range(0, 255))});
    endtask

    function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == a || c == b);
        return c;
    endfunction

    // unquoted word byte, mostly letters so the streams look like shell text
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 3) != 0)
                c = 8'($urandom_range(8'h61, 8'h7A));
            else
                c = 8'($urandom_range(0, 255));
        end
        while (c == swt_pkg::CH_SPACE || c == swt_pkg::CH_SEMI || c == swt_pkg::CH_NL
               || c == swt_pkg::CH_SQ || c == swt_pkg::CH_DQ || c == swt_pkg::CH_BSL);
        return c;
    endfunction

    // one word made of plain runs, quoted regions and escapes
    task automatic gen_word();
        int unsigned pieces;
        int unsigned n;
        pieces = $urandom_range(1, 4);
        repeat (pieces)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    n = $urandom_range(1, 5);
                    repeat (n) add_data(plain_char());
                end
                1:
                begin
                    // single quotes: anything goes inside except the quote
                    add_data(swt_pkg::CH_SQ);
                    n = $urandom_range(0, 4);
                    repeat (n) add_data(byte_except(swt_pkg::CH_SQ, swt_pkg::CH_SQ));
                    add_data(swt_pkg::CH_SQ);
                end
                2:
                begin
                    // double quotes with occasional escapes
                    add_data(swt_pkg::CH_DQ);
                    n = $urandom_range(0, 4);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            add_data(swt_pkg::CH_BSL);
                            add_data(8'($urandom_range(0, 255)));
                        end
                        else
                            add_data(byte_except(swt_pkg::CH_DQ, swt_pkg::CH_BSL));
                    end
                    add_data(swt_pkg::CH_DQ);
                end
                default:
                begin
                    add_data(swt_pkg::CH_BSL);
                    add_data(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // a command line: words and separators, then a line end or end marker
    task automatic gen_line();
        int unsigned toks;
        int unsigned n;
        toks = $urandom_range(1, 5);
        if ($urandom_range(0, 3) == 0)
            add_data(swt_pkg::CH_SPACE);
        for (int i = 0; i < toks; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                add_data(swt_pkg::CH_SEMI);
            else
                gen_word();
            if (i + 1 < toks && $urandom_range(0, 3) != 0)
            begin
                n = $urandom_range(1, 2);
                repeat (n) add_data(swt_pkg::CH_SPACE);
            end
        end
        case ($urandom_range(0, 7))
            0: add_end();
            1:
            begin
                add_data(swt_pkg::CH_SEMI);
                add_data(swt_pkg::CH_NL);
            end
            default:
            begin
                add_data(swt_pkg::CH_NL);
                n = $urandom_range(0, 3);
                repeat (n)
                    add_data($urandom_range(0, 1) ? swt_pkg::CH_NL : swt_pkg::CH_SPACE);
            end
        endcase
    endtask

    // unterminated quote, possibly with a pending escape, cut by end of input
    task automatic gen_broken();
        int unsigned n;
        if ($urandom_range(0, 1) != 0)
            gen_word();
        add_data($urandom_range(0, 1) ? swt_pkg::CH_SQ : swt_pkg::CH_DQ);
        n = $urandom_range(0, 3);
        repeat (n) add_data(plain_char());
        if ($urandom_range(0, 2) == 0)
            add_data(swt_pkg::CH_BSL);
        add_end();
    endtask

    // raw noise: any byte, now and then an end marker
    task automatic gen_noise();
        int unsigned n;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                add_end();
            else
                add_data(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic fill_random(input int unsigned target);
        while (byte_feed.size() < target)
        begin
            case ($urandom_range(0, 9))
                7: gen_broken();
                8: gen_noise();
                9:
                begin
                    // end of input right inside a word
                    gen_word();
                    add_end();
                end
                default: gen_line();
            endcase
        end
    endtask

    // hold off new bytes until every tag has come back
    task automatic drain();
        while (byte_feed.size() != 0 || tag_expect.size() != 0 || in_valid)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_rates(input int unsigned idle, input int unsigned stall);
        idle_pct = idle;
        stall_pct = stall;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed stream, no idling
        set_rates(0, 0);
        add_data(8'h00);                // zero byte is a plain word byte
        add_data(8'hFF);
        add_data(swt_pkg::CH_SPACE);    // closes the word
        add_data(swt_pkg::CH_SEMI);     // separator
        add_data(swt_pkg::CH_NL);       // linebreak
        add_data(swt_pkg::CH_NL);       // absorbed, still counted
        add_data(swt_pkg::CH_SPACE);    // absorbed
        add_end();                      // end right after a linebreak
        add_data(8'h62);
        add_data(swt_pkg::CH_SQ);       // quote opens inside a word
        add_data(swt_pkg::CH_NL);       // quoted newline is a word byte
        add_data(swt_pkg::CH_SQ);
        add_data(swt_pkg::CH_DQ);
        add_data(swt_pkg::CH_BSL);      // escape inside double quotes
        add_data(swt_pkg::CH_DQ);
        add_data(swt_pkg::CH_DQ);
        add_data(swt_pkg::CH_BSL);
        add_data(swt_pkg::CH_NL);       // escaped newline, no line count
        add_end();                      // end inside a word
        add_data(swt_pkg::CH_BSL);
        add_end();                      // trailing backslash
        add_data(swt_pkg::CH_SQ);
        add_end();                      // open single quote
        add_data(swt_pkg::CH_DQ);
        add_data(swt_pkg::CH_BSL);
        add_end();                      // pending escape in double quotes
        drain();

        // random phases with different idle and stall patterns
        set_rates(0, 0);
        fill_random(130);
        drain();

        set_rates(75, 0);
        fill_random(130);
        drain();

        set_rates(0, 75);
        fill_random(130);
        drain();

        set_rates(30, 30);
        fill_random(130);
        drain();

        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- shell_word_tokenizer_top.f -----
rtl/core/swt_pkg.sv
rtl/core/shell_word_tokenizer_top.sv
rtl/core/swt_checker.sv
tb/sv/shell_word_tokenizer_top_test.sv
